@@ hw/rtl/llcp_pkg.sv @@
// Shared widths, request and result types for the closest-point solver.
package llcp_pkg;

    // Coordinate and intermediate widths
    localparam int COORD_BITS          = 16;
    localparam int DIFF_W              = COORD_BITS + 1;
    localparam int PROD_W              = 2 * DIFF_W;
    localparam int DOT_W               = PROD_W + 2;
    localparam int WIDE_W              = 2 * DOT_W;
    localparam int NUM_W               = WIDE_W + 1;

    // Result format
    localparam int PARAM_W             = 32;
    localparam int QUO_W               = PARAM_W + 1;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    // Queue between front and back
    localparam int FIFO_DEPTH          = 4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] p1_x;
        logic signed [COORD_BITS-1:0] p1_y;
        logic signed [COORD_BITS-1:0] p1_z;
        logic signed [COORD_BITS-1:0] p2_x;
        logic signed [COORD_BITS-1:0] p2_y;
        logic signed [COORD_BITS-1:0] p2_z;
        logic signed [COORD_BITS-1:0] q1_x;
        logic signed [COORD_BITS-1:0] q1_y;
        logic signed [COORD_BITS-1:0] q1_z;
        logic signed [COORD_BITS-1:0] q2_x;
        logic signed [COORD_BITS-1:0] q2_y;
        logic signed [COORD_BITS-1:0] q2_z;
    } req_in_t;

    typedef struct packed {
        logic signed [PARAM_W-1:0] param_s;
        logic signed [PARAM_W-1:0] param_t;
        logic                      parallel_flag;
        logic                      saturated_flag;
    } res_out_t;

    // Queue entry: determinant and the two Cramer numerators
    typedef struct packed {
        logic signed [NUM_W-1:0] det;
        logic signed [NUM_W-1:0] num_s;
        logic signed [NUM_W-1:0] num_t;
    } solve_t;

endpackage

@@ hw/rtl/llcp_wmul.sv @@
// Two-stage signed multiplier, split on the second operand's halves.
module llcp_wmul
    import llcp_pkg::*;
#(
    parameter int AW = DOT_W
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [AW-1:0]   x,
    input  logic signed [AW-1:0]   y,
    output logic signed [2*AW-1:0] p
);

    localparam int HW     = AW / 2;
    localparam int HIW    = AW - HW;
    localparam int LOW_PW = AW + HW + 1;
    localparam int HI_PW  = AW + HIW;

    logic signed [LOW_PW-1:0] lo_reg, lo_next;
    logic signed [HI_PW-1:0]  hi_reg, hi_next;
    logic signed [2*AW-1:0]   p_reg, p_next;

    // Partial products against low (unsigned) and high (signed) halves
    always_comb
    begin
        lo_next = LOW_PW'(x) * LOW_PW'($signed({1'b0, y[HW-1:0]}));
        hi_next = HI_PW'(x) * HI_PW'($signed(y[AW-1:HW]));
    end

    // Recombine
    always_comb
    begin
        p_next = (2*AW)'(lo_reg) + ((2*AW)'(hi_reg) <<< HW);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            p_reg  <= p_next;
        end
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/llcp_front.sv @@
// Front pipeline: direction vectors, dot products, determinant and numerators.
module llcp_front
    import llcp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  req_in_t in_data,
    output logic    push_valid,
    input  logic    push_full,
    output solve_t  push_data
);

    localparam int NSTG = 6;

    logic en;
    logic [NSTG-1:0] v_reg;

    logic signed [DIFF_W-1:0] u_reg [3];
    logic signed [DIFF_W-1:0] v3_reg [3];
    logic signed [DIFF_W-1:0] w_reg [3];
    logic signed [DIFF_W-1:0] p1 [3], p2 [3], q1 [3], q2 [3];

    logic signed [PROD_W-1:0] uu_reg [3], vv_reg [3], uv_reg [3], wu_reg [3], wv_reg [3];
    logic signed [DOT_W-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic signed [WIDE_W-1:0] ab, cc, ce, bd, ae, cd;
    solve_t                   sol_reg, sol_next;

    // Whole front holds when its last stage cannot enter the queue
    assign en       = !(v_reg[NSTG-1] && push_full);
    assign in_ready = en;

    assign p1 = '{DIFF_W'(in_data.p1_x), DIFF_W'(in_data.p1_y), DIFF_W'(in_data.p1_z)};
    assign p2 = '{DIFF_W'(in_data.p2_x), DIFF_W'(in_data.p2_y), DIFF_W'(in_data.p2_z)};
    assign q1 = '{DIFF_W'(in_data.q1_x), DIFF_W'(in_data.q1_y), DIFF_W'(in_data.q1_z)};
    assign q2 = '{DIFF_W'(in_data.q2_x), DIFF_W'(in_data.q2_y), DIFF_W'(in_data.q2_z)};

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    // Stages 0 to 2: differences, products, dot sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                u_reg[k]  <= p2[k] - p1[k];
                v3_reg[k] <= q2[k] - q1[k];
                w_reg[k]  <= p1[k] - q1[k];
                uu_reg[k] <= PROD_W'(u_reg[k]) * PROD_W'(u_reg[k]);
                vv_reg[k] <= PROD_W'(v3_reg[k]) * PROD_W'(v3_reg[k]);
                uv_reg[k] <= PROD_W'(u_reg[k]) * PROD_W'(v3_reg[k]);
                wu_reg[k] <= PROD_W'(w_reg[k]) * PROD_W'(u_reg[k]);
                wv_reg[k] <= PROD_W'(w_reg[k]) * PROD_W'(v3_reg[k]);
            end
            a_reg <= DOT_W'(uu_reg[0]) + DOT_W'(uu_reg[1]) + DOT_W'(uu_reg[2]);
            b_reg <= DOT_W'(vv_reg[0]) + DOT_W'(vv_reg[1]) + DOT_W'(vv_reg[2]);
            c_reg <= DOT_W'(uv_reg[0]) + DOT_W'(uv_reg[1]) + DOT_W'(uv_reg[2]);
            d_reg <= DOT_W'(wu_reg[0]) + DOT_W'(wu_reg[1]) + DOT_W'(wu_reg[2]);
            e_reg <= DOT_W'(wv_reg[0]) + DOT_W'(wv_reg[1]) + DOT_W'(wv_reg[2]);
            sol_reg <= sol_next;
        end
    end

    // Stages 3 and 4: wide products
    llcp_wmul #(.AW(DOT_W)) u_ab (.clk(clk), .en(en), .x(a_reg), .y(b_reg), .p(ab));
    llcp_wmul #(.AW(DOT_W)) u_cc (.clk(clk), .en(en), .x(c_reg), .y(c_reg), .p(cc));
    llcp_wmul #(.AW(DOT_W)) u_ce (.clk(clk), .en(en), .x(c_reg), .y(e_reg), .p(ce));
    llcp_wmul #(.AW(DOT_W)) u_bd (.clk(clk), .en(en), .x(b_reg), .y(d_reg), .p(bd));
    llcp_wmul #(.AW(DOT_W)) u_ae (.clk(clk), .en(en), .x(a_reg), .y(e_reg), .p(ae));
    llcp_wmul #(.AW(DOT_W)) u_cd (.clk(clk), .en(en), .x(c_reg), .y(d_reg), .p(cd));

    // Stage 5: determinant and numerators
    always_comb
    begin
        sol_next.det   = NUM_W'(ab) - NUM_W'(cc);
        sol_next.num_s = NUM_W'(ce) - NUM_W'(bd);
        sol_next.num_t = NUM_W'(ae) - NUM_W'(cd);
    end

    assign push_valid = v_reg[NSTG-1];
    assign push_data  = sol_reg;

endmodule

@@ hw/rtl/llcp_fifo.sv @@
// Short request queue between the front and back pipelines.
module llcp_fifo
    import llcp_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_full,
    input  solve_t push_data,
    output logic   pop_valid,
    input  logic   pop_ready,
    output solve_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    solve_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign push_full = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign push      = push_valid && !push_full;
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = mem[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/llcp_back.sv @@
// Back pipeline: two restoring dividers, one quotient bit per stage, then saturation.
module llcp_back
    import llcp_pkg::*;
#(
    parameter int FRAC = PARAM_FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pop_valid,
    output logic     pop_ready,
    input  solve_t   pop_data,
    output logic     out_valid,
    input  logic     out_ready,
    output res_out_t out_data
);

    localparam int CW = NUM_W + QUO_W;

    logic en;

    // Per-stage registers; stage 0 is preparation, stage j resolves bit QUO_W-j
    logic             v_reg   [QUO_W+1];
    logic             par_reg [QUO_W+1];
    logic             ngs_reg [QUO_W+1];
    logic             ngt_reg [QUO_W+1];
    logic             bgs_reg [QUO_W+1];
    logic             bgt_reg [QUO_W+1];
    logic [NUM_W-1:0] det_reg [QUO_W+1];
    logic [CW-1:0]    rs_reg  [QUO_W+1];
    logic [CW-1:0]    rt_reg  [QUO_W+1];
    logic [QUO_W-1:0] qs_reg  [QUO_W+1];
    logic [QUO_W-1:0] qt_reg  [QUO_W+1];

    logic             out_valid_reg;
    res_out_t         out_data_reg, out_data_next;

    logic [NUM_W-1:0] mag_s, mag_t, det_u;
    logic [CW-1:0]    m_s, m_t, det_top;

    assign en        = !out_valid_reg || out_ready;
    assign pop_ready = en;

    // Preparation: magnitudes, scaling, overflow check against det << QUO_W
    always_comb
    begin
        det_u   = pop_data.det;
        mag_s   = pop_data.num_s[NUM_W-1] ? -pop_data.num_s : pop_data.num_s;
        mag_t   = pop_data.num_t[NUM_W-1] ? -pop_data.num_t : pop_data.num_t;
        m_s     = CW'(mag_s) << FRAC;
        m_t     = CW'(mag_t) << FRAC;
        det_top = CW'(det_u) << QUO_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= pop_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg[0] <= (pop_data.det == '0);
            ngs_reg[0] <= pop_data.num_s[NUM_W-1];
            ngt_reg[0] <= pop_data.num_t[NUM_W-1];
            bgs_reg[0] <= (m_s >= det_top);
            bgt_reg[0] <= (m_t >= det_top);
            det_reg[0] <= det_u;
            rs_reg[0]  <= m_s;
            rt_reg[0]  <= m_t;
            qs_reg[0]  <= '0;
            qt_reg[0]  <= '0;
        end
    end

    // Divider stages
    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_div
        localparam int BIT = QUO_W - j;
        logic [CW-1:0] dsh;
        logic          ge_s, ge_t;

        always_comb
        begin
            dsh  = CW'(det_reg[j-1]) << BIT;
            ge_s = (rs_reg[j-1] >= dsh);
            ge_t = (rt_reg[j-1] >= dsh);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                par_reg[j] <= par_reg[j-1];
                ngs_reg[j] <= ngs_reg[j-1];
                ngt_reg[j] <= ngt_reg[j-1];
                bgs_reg[j] <= bgs_reg[j-1];
                bgt_reg[j] <= bgt_reg[j-1];
                det_reg[j] <= det_reg[j-1];
                rs_reg[j]  <= ge_s ? rs_reg[j-1] - dsh : rs_reg[j-1];
                rt_reg[j]  <= ge_t ? rt_reg[j-1] - dsh : rt_reg[j-1];
                qs_reg[j]  <= qs_reg[j-1] | (QUO_W'(ge_s) << BIT);
                qt_reg[j]  <= qt_reg[j-1] | (QUO_W'(ge_t) << BIT);
            end
        end
    end

    // Saturation, sign and the parallel case
    logic [QUO_W-1:0]   lim_s, lim_t;
    logic               sat_s, sat_t;
    logic [PARAM_W-1:0] ms, mt;

    always_comb
    begin
        lim_s = ngs_reg[QUO_W] ? (QUO_W'(1) << (PARAM_W - 1))
                               : ((QUO_W'(1) << (PARAM_W - 1)) - 1'b1);
        lim_t = ngt_reg[QUO_W] ? (QUO_W'(1) << (PARAM_W - 1))
                               : ((QUO_W'(1) << (PARAM_W - 1)) - 1'b1);
        sat_s = bgs_reg[QUO_W] || (qs_reg[QUO_W] > lim_s);
        sat_t = bgt_reg[QUO_W] || (qt_reg[QUO_W] > lim_t);
        ms    = sat_s ? lim_s[PARAM_W-1:0] : qs_reg[QUO_W][PARAM_W-1:0];
        mt    = sat_t ? lim_t[PARAM_W-1:0] : qt_reg[QUO_W][PARAM_W-1:0];
        if (par_reg[QUO_W])
        begin
            out_data_next.param_s        = '0;
            out_data_next.param_t        = '0;
            out_data_next.parallel_flag  = 1'b1;
            out_data_next.saturated_flag = 1'b0;
        end
        else
        begin
            out_data_next.param_s        = ngs_reg[QUO_W] ? -ms : ms;
            out_data_next.param_t        = ngt_reg[QUO_W] ? -mt : mt;
            out_data_next.parallel_flag  = 1'b0;
            out_data_next.saturated_flag = sat_s || sat_t;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/line_line_closest_params_top.sv @@
// Top level of the closest-point solver for two 3D lines.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | in_data   (req_in_t: P1, P2, Q1, Q2)
//  out     | output    | out_valid/out_ready | out_data  (res_out_t: s, t, flags)
//
// One request per cycle sustained while the output is not stalled. The path runs through 6 front stages
// (dot products, two-stage wide multipliers), the queue,
// and 35 back stages set by the dividers, which resolve one quotient bit per stage.
// Reset clears only valid bits, queue pointers and fill count, and the output valid.
// A stalled output holds the back pipeline; the 4-entry queue lets the front keep
// accepting until it fills and a result waits at the front's last stage; then in_ready drops.
module line_line_closest_params_top
    import llcp_pkg::*;
#(
    parameter int PARAM_FRAC_BITS = PARAM_FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  req_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output res_out_t out_data
);

    logic   push_valid, push_full, pop_valid, pop_ready;
    solve_t push_data, pop_data;

    llcp_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .push_valid(push_valid), .push_full(push_full), .push_data(push_data)
    );

    llcp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .push_valid(push_valid), .push_full(push_full), .push_data(push_data),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
    );

    llcp_back #(.FRAC(PARAM_FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

endmodule

@@ hw/rtl/llcp_checker.sv @@
// Port-level assertions for the solver top level, with their bind.
module llcp_checker
    import llcp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input res_out_t out_data
);

    logic [7:0] pend_reg;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Requests in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    // No result without a request behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != '0))
        else $error("result without pending request");

    // Parallel case gives zero parameters and no saturation
    a_parallel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.parallel_flag) |->
        (out_data.param_s == '0 && out_data.param_t == '0 && !out_data.saturated_flag))
        else $error("parallel result not cleared");

    // Saturation leaves at least one parameter at a limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.saturated_flag) |->
        (out_data.param_s == 32'sh7FFFFFFF || out_data.param_s == 32'sh80000000 ||
         out_data.param_t == 32'sh7FFFFFFF || out_data.param_t == 32'sh80000000))
        else $error("saturation flag without clipped value");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind line_line_closest_params_top llcp_checker u_llcp_checker (.*);
